[rtl/adfo_pkg.sv]
// ----------------------------------------------------------------------------
// adfo_pkg
// Shared types, constants and the quarter-wave sine table builder for the
// adaptive frequency oscillator step block.
// ----------------------------------------------------------------------------
package adfo_pkg;

  localparam int PHASE_BITS     = 48;
  localparam int SINE_ADDR_BITS = 10;
  localparam int SINE_BITS      = 16;

  localparam int SINE_DEPTH = 1 << SINE_ADDR_BITS;
  localparam int SMAG_W     = SINE_BITS - 1;           // table magnitude width
  localparam int MAG_W      = 2 * (SINE_BITS - 1);     // |sin * sin| width
  localparam int PROD_SHIFT = MAG_W;
  localparam int HALF_W     = (PHASE_BITS + 1) / 2;    // low half of a gain
  localparam int HIGH_W     = PHASE_BITS - HALF_W;
  localparam int MUL_A_W    = (HALF_W > SMAG_W) ? HALF_W : SMAG_W;
  localparam int MUL_B_W    = MAG_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = PHASE_BITS + MAG_W + 1;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_GAIN   = 3'd0,
    REG_FREQ_GAIN    = 3'd1,
    REG_FORCING_STEP = 3'd2,
    REG_INIT_FREQ    = 3'd3,
    REG_INIT_PHASE   = 3'd4
  } cfg_reg_e;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [SMAG_W-1:0]     sine_mag_t;
  typedef sine_mag_t             sine_tab_t [SINE_DEPTH];

  localparam phase_t RST_PHASE_GAIN   = PHASE_BITS'(64'd44798200000000);
  localparam phase_t RST_FREQ_GAIN    = PHASE_BITS'(64'd4479820);
  localparam phase_t RST_FORCING_STEP = PHASE_BITS'(64'd447982000);
  localparam phase_t RST_INIT_FREQ    = PHASE_BITS'(64'd44798200);
  localparam phase_t RST_INIT_PHASE   = '0;

  localparam phase_t PSIGN = phase_t'(1) << (PHASE_BITS - 1);

  // Taylor series divisors (2n)(2n+1) for n = 1..8
  localparam longint unsigned TaylorDiv [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };
  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint          OneQ30 = 64'sd1 << 30;
  localparam longint          Amp    = (64'sd1 << (SINE_BITS - 1)) - 64'sd1;

  // Entry k: sin((k + 1/2) * (pi/2) / depth) * Amp, Q2.30 series, rounded.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x    = ((64'd2 * longint'(k) + 64'd1) * PiQ30) >> (SINE_ADDR_BITS + 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / TaylorDiv[n-1];
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > OneQ30) begin
        sum = OneQ30;
      end
      tab[k] = SMAG_W'((sum * Amp + (OneQ30 >>> 1)) >>> 30);
    end
    return tab;
  endfunction

  // Table index: top bits below the quadrant, mirrored in odd quadrants.
  function automatic logic [SINE_ADDR_BITS-1:0] sine_index(phase_t ph);
    logic [SINE_ADDR_BITS-1:0] idx;
    idx = ph[PHASE_BITS-3 -: SINE_ADDR_BITS];
    return ph[PHASE_BITS-2] ? ~idx : idx;
  endfunction

endpackage

[rtl/adfo_if.sv]
// ----------------------------------------------------------------------------
// adfo_if
// Valid/ready channels of the oscillator step block: step item, result word
// and configuration write.
// ----------------------------------------------------------------------------
interface adfo_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface adfo_out_if
  import adfo_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic        [PHASE_BITS-1:0] phase_out;
  logic signed [PHASE_BITS-1:0] freq_out;
  logic        [PHASE_BITS-1:0] forcing_out;

  modport source (output valid, output phase_out, output freq_out, output forcing_out,
                  input ready);
  modport sink   (input valid, input phase_out, input freq_out, input forcing_out,
                  output ready);
endinterface

interface adfo_cfg_if
  import adfo_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [PHASE_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/adaptive_frequency_oscillator_step_top.sv]
// ----------------------------------------------------------------------------
// adaptive_frequency_oscillator_step_top
// One Euler tick of a phase oscillator that adapts its frequency to an
// internal sinusoidal forcing, on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   item_i   : step word, restart = 1 reloads the initial phase/frequency
//              and clears the forcing phase, restart = 0 advances one tick.
//   result_o : phase, frequency step and forcing phase after the word.
//   cfg_i    : register writes (always ready); write only while idle.
// Timing: a step word runs through SIN_A, SIN_B, MAG, PL, PH, FL, FH and TF
//   to UPD, a restart word goes straight to UPD. The sequence is set by the
//   single multiplier, used five times per step (sine product, two halves of
//   each gain product), and the single-port sine ROM read twice. item_i is
//   ready only while idle, so one word is in work at a time.
// Output: a registered result slot. The next word is accepted while a
//   result waits; if the slot is still full when that word finishes, the
//   block holds in its update state until result_o is taken.
// Reset: gains, forcing step and initial values return to defaults, the
//   oscillator state is loaded from them and the result slot is emptied.
// ----------------------------------------------------------------------------
module adaptive_frequency_oscillator_step_top
  import adfo_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  adfo_in_if.sink    item_i,
  adfo_out_if.source result_o,
  adfo_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_SIN_A, S_SIN_B, S_MAG, S_PL, S_PH, S_FL, S_FH, S_TF, S_UPD
  } state_e;

  localparam sine_tab_t SineRom = build_sine_tab();
  localparam logic [ACC_W-1:0] Rnd = ACC_W'(1) << (PROD_SHIFT - 1);

  state_e state_q;
  logic   restart_q;

  // configuration
  phase_t phase_gain_q, freq_gain_q, forcing_step_q, init_freq_q, init_phase_q;

  // oscillator state
  phase_t osc_q, freq_q, forcing_q;

  // result slot
  logic   out_valid_q;
  phase_t out_phase_q, out_freq_q, out_forcing_q;

  // datapath
  logic [SINE_ADDR_BITS-1:0] rom_addr;
  sine_mag_t                 rom_q, mag_a_q;
  logic [MAG_W-1:0]          mag_q;
  logic                      neg_q;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [PROD_W-1:0]         prod_q;
  logic [ACC_W-1:0]          acc_q, acc_sum;
  phase_t                    tp_q, tf_q;

  logic   item_acc, commit;
  phase_t off, off_n, phase_n, freq_n, forcing_n;

  assign item_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign item_acc     = item_i.valid && item_i.ready;
  assign commit       = (state_q == S_UPD) && (!out_valid_q || result_o.ready);

  assign result_o.valid       = out_valid_q;
  assign result_o.phase_out   = out_phase_q;
  assign result_o.freq_out    = out_freq_q;
  assign result_o.forcing_out = out_forcing_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_gain_q   <= RST_PHASE_GAIN;
      freq_gain_q    <= RST_FREQ_GAIN;
      forcing_step_q <= RST_FORCING_STEP;
      init_freq_q    <= RST_INIT_FREQ;
      init_phase_q   <= RST_INIT_PHASE;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_PHASE_GAIN:   phase_gain_q   <= cfg_i.data;
        REG_FREQ_GAIN:    freq_gain_q    <= cfg_i.data;
        REG_FORCING_STEP: forcing_step_q <= cfg_i.data;
        REG_INIT_FREQ:    init_freq_q    <= cfg_i.data;
        REG_INIT_PHASE:   init_phase_q   <= cfg_i.data;
        default:          ;
      endcase
    end
  end

  // sine ROM, one registered read port: osc phase while idle, forcing after
  assign rom_addr = (state_q == S_IDLE) ? sine_index(osc_q) : sine_index(forcing_q);

  always_ff @(posedge clk_i) begin
    rom_q <= SineRom[rom_addr];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SIN_B: begin
        mul_a = MUL_A_W'(mag_a_q);
        mul_b = MUL_B_W'(rom_q);
      end
      S_PL: begin
        mul_a = MUL_A_W'(phase_gain_q[HALF_W-1:0]);
        mul_b = mag_q;
      end
      S_PH: begin
        mul_a = MUL_A_W'(phase_gain_q[PHASE_BITS-1:HALF_W]);
        mul_b = mag_q;
      end
      S_FL: begin
        mul_a = MUL_A_W'(freq_gain_q[HALF_W-1:0]);
        mul_b = mag_q;
      end
      S_FH: begin
        mul_a = MUL_A_W'(freq_gain_q[PHASE_BITS-1:HALF_W]);
        mul_b = mag_q;
      end
      default: ;
    endcase
  end

  // rounded gain term: (lo + rnd) + (hi << half), then drop the product scale
  assign acc_sum = acc_q + (ACC_W'(prod_q) << HALF_W);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_SIN_A: mag_a_q <= rom_q;
      S_MAG: begin
        mag_q <= prod_q[MAG_W-1:0];
        neg_q <= osc_q[PHASE_BITS-1] ^ forcing_q[PHASE_BITS-1];
      end
      S_PH:    acc_q <= ACC_W'(prod_q) + Rnd;
      S_FL:    tp_q  <= acc_sum[PROD_SHIFT +: PHASE_BITS];
      S_FH:    acc_q <= ACC_W'(prod_q) + Rnd;
      S_TF:    tf_q  <= acc_sum[PROD_SHIFT +: PHASE_BITS];
      default: ;
    endcase
  end

  // state update; frequency saturates in offset-binary form
  always_comb begin
    off = freq_q ^ PSIGN;
    if (neg_q) begin
      off_n   = (tf_q > ~off) ? '1 : off + tf_q;
      phase_n = osc_q + freq_q + tp_q;
    end else begin
      off_n   = (tf_q > off) ? '0 : off - tf_q;
      phase_n = osc_q + freq_q - tp_q;
    end
    freq_n    = off_n ^ PSIGN;
    forcing_n = forcing_q + forcing_step_q;
    if (restart_q) begin
      phase_n   = init_phase_q;
      freq_n    = init_freq_q;
      forcing_n = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      restart_q     <= 1'b0;
      osc_q         <= RST_INIT_PHASE;
      freq_q        <= RST_INIT_FREQ;
      forcing_q     <= '0;
      out_valid_q   <= 1'b0;
      out_phase_q   <= '0;
      out_freq_q    <= '0;
      out_forcing_q <= '0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (result_o.valid && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (item_acc) begin
            restart_q <= item_i.restart;
            state_q   <= item_i.restart ? S_UPD : S_SIN_A;
          end
        end
        S_SIN_A: state_q <= S_SIN_B;
        S_SIN_B: state_q <= S_MAG;
        S_MAG:   state_q <= S_PL;
        S_PL:    state_q <= S_PH;
        S_PH:    state_q <= S_FL;
        S_FL:    state_q <= S_FH;
        S_FH:    state_q <= S_TF;
        S_TF:    state_q <= S_UPD;
        S_UPD: begin
          if (commit) begin
            osc_q         <= phase_n;
            freq_q        <= freq_n;
            forcing_q     <= forcing_n;
            out_phase_q   <= phase_n;
            out_freq_q    <= freq_n;
            out_forcing_q <= forcing_n;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_restart_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && restart_q) |=> (osc_q == $past(init_phase_q)) && (forcing_q == '0))
    else $error("restart did not reload the oscillator state");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(forcing_q) && $stable(osc_q) && $stable(freq_q))
    else $error("oscillator state changed outside an update");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc |=> (state_q != S_IDLE))
    else $error("accepted word did not start work");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(commit))
    else $error("result valid without an update");
`endif

endmodule

[test/adaptive_frequency_oscillator_step_top_tb.sv]
// ----------------------------------------------------------------------------
// adaptive_frequency_oscillator_step_top_tb
// Self-checking bench for the oscillator step block. A queue-fed driver sends
// step and restart words, a clocked monitor compares every result word with a
// bit-accurate predictor of the Euler tick. Register settings change between
// batches, only while the block is idle. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module adaptive_frequency_oscillator_step_top_tb;
  import adfo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CYCLE_LIMIT = 200000;
  localparam int     DRAIN_WAIT  = 14;
  localparam phase_t ALL_ONES    = '1;
  localparam phase_t MOST_NEG    = PSIGN;
  localparam phase_t MOST_POS    = ~PSIGN;
  localparam phase_t QUARTER     = phase_t'(1) << (PHASE_BITS - 2);
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    phase_t phase;
    phase_t freq;
    phase_t forcing;
  } tick_t;

  logic clk_i  = 1'b0;
  logic rst_ni;

  adfo_in_if  item_if ();
  adfo_out_if result_if ();
  adfo_cfg_if cfg_if ();

  adaptive_frequency_oscillator_step_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state and register copies
  int     quarter_wave [SINE_DEPTH];
  phase_t k_phase;
  phase_t k_freq;
  phase_t forcing_inc;
  phase_t start_freq;
  phase_t start_phase;
  phase_t cur_phase;
  phase_t cur_freq;
  phase_t cur_forcing;

  bit    step_words [$];
  tick_t due_results [$];
  bit    calm;
  int    errors;
  int    cycles;

  function automatic void fill_quarter_wave();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x    = ((64'd2 * longint'(k) + 64'd1) * PI_Q30) >> (SINE_ADDR_BITS + 2);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        acc  = n[0] ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
      quarter_wave[k] = int'((acc * ((64'sd1 << (SINE_BITS - 1)) - 1) + (64'sd1 << 29)) >>> 30);
    end
  endfunction

  function automatic int sine_at(phase_t ph);
    logic [SINE_ADDR_BITS+1:0] top;
    logic [SINE_ADDR_BITS-1:0] idx;
    top = ph[PHASE_BITS-1 -: SINE_ADDR_BITS+2];
    idx = top[SINE_ADDR_BITS-1:0];
    if (top[SINE_ADDR_BITS]) idx = ~idx;
    return top[SINE_ADDR_BITS+1] ? -quarter_wave[idx] : quarter_wave[idx];
  endfunction

  // round(g * m / 2^PROD_SHIFT), ties away from zero
  function automatic logic [63:0] gain_term(phase_t g, longint unsigned m);
    logic [127:0] w;
    w = 128'(g) * 128'(m) + (128'(1) << (PROD_SHIFT - 1));
    return w[PROD_SHIFT +: 64];
  endfunction

  function automatic void reload_state();
    cur_phase   = start_phase;
    cur_freq    = start_freq;
    cur_forcing = '0;
  endfunction

  function automatic tick_t tick_oscillator(bit restart);
    tick_t           r;
    longint          sp;
    longint unsigned mag;
    logic [63:0]     tp;
    logic [63:0]     tf;
    phase_t          off;
    phase_t          room;
    if (restart) begin
      reload_state();
    end else begin
      sp  = longint'(sine_at(cur_phase)) * longint'(sine_at(cur_forcing));
      mag = (sp < 0) ? longint'(-sp) : sp;
      tp  = gain_term(k_phase, mag);
      tf  = gain_term(k_freq, mag);
      off = cur_freq ^ PSIGN;           // offset binary, saturate on it
      if (sp < 0) begin
        cur_phase = cur_phase + cur_freq + tp[PHASE_BITS-1:0];
        room      = ALL_ONES - off;
        off       = (tf > 64'(room)) ? ALL_ONES : off + tf[PHASE_BITS-1:0];
      end else begin
        cur_phase = cur_phase + cur_freq - tp[PHASE_BITS-1:0];
        off       = (tf > 64'(off)) ? '0 : off - tf[PHASE_BITS-1:0];
      end
      cur_freq    = off ^ PSIGN;
      cur_forcing = cur_forcing + forcing_inc;
    end
    r.phase   = cur_phase;
    r.freq    = cur_freq;
    r.forcing = cur_forcing;
    return r;
  endfunction

  function automatic phase_t pick_value();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return phase_t'($urandom_range(0, 65535));
      3:       return phase_t'({$urandom, $urandom}) >> $urandom_range(0, 47);
      4:       return phase_t'(1) << $urandom_range(0, PHASE_BITS - 1);
      default: return phase_t'({$urandom, $urandom});
    endcase
  endfunction

  // driver: steps words out of step_words
  int idle_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_if.valid   <= 1'b0;
      item_if.restart <= 1'b0;
      idle_left       <= 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        due_results.push_back(tick_oscillator(item_if.restart));
      end
      if (!item_if.valid || item_if.ready) begin
        if (idle_left != 0) begin
          item_if.valid <= 1'b0;
          idle_left     <= idle_left - 1;
        end else if (step_words.size() != 0) begin
          item_if.valid   <= 1'b1;
          item_if.restart <= step_words.pop_front();
          if (!calm && $urandom_range(0, 3) == 0) idle_left <= $urandom_range(1, 11);
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result words, stalls ready in bursts
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      stall_left      <= 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          tick_t exp_r;
          exp_r = due_results.pop_front();
          if (result_if.phase_out !== exp_r.phase) begin
            $error("phase_out: expected %h, got %h", exp_r.phase, result_if.phase_out);
            errors++;
          end
          if (result_if.freq_out !== exp_r.freq) begin
            $error("freq_out: expected %h, got %h", exp_r.freq, result_if.freq_out);
            errors++;
          end
          if (result_if.forcing_out !== exp_r.forcing) begin
            $error("forcing_out: expected %h, got %h", exp_r.forcing, result_if.forcing_out);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        result_if.ready <= 1'b0;
        stall_left      <= stall_left - 1;
      end else begin
        result_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) stall_left <= $urandom_range(1, 11);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, phase_t value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_PHASE_GAIN:   k_phase     = value;
      REG_FREQ_GAIN:    k_freq      = value;
      REG_FORCING_STEP: forcing_inc = value;
      REG_INIT_FREQ:    start_freq  = value;
      REG_INIT_PHASE:   start_phase = value;
      default:          ;
    endcase
  endtask

  // sender holds until all results are in, then lets the block go quiet
  task automatic settle();
    while (step_words.size() != 0 || item_if.valid) @(negedge clk_i);
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  initial begin
    logic [CFG_IDX_W-1:0] bad_idx;
    rst_ni          = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    calm            = 1'b0;
    fill_quarter_wave();
    k_phase     = RST_PHASE_GAIN;
    k_freq      = RST_FREQ_GAIN;
    forcing_inc = RST_FORCING_STEP;
    start_freq  = RST_INIT_FREQ;
    start_phase = RST_INIT_PHASE;
    reload_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: step straight out of reset, then restart
    @(negedge clk_i);
    repeat (6) step_words.push_back(1'b0);
    step_words.push_back(1'b1);
    repeat (3) step_words.push_back(1'b0);
    settle();

    // everything at its top: phase wrap and positive saturation
    write_reg(REG_PHASE_GAIN, ALL_ONES);
    write_reg(REG_FREQ_GAIN, ALL_ONES);
    write_reg(REG_FORCING_STEP, ALL_ONES);
    write_reg(REG_INIT_FREQ, MOST_POS);
    write_reg(REG_INIT_PHASE, ALL_ONES);
    @(negedge clk_i);
    step_words.push_back(1'b1);
    repeat (5) step_words.push_back(1'b0);
    settle();

    // most negative start, no phase coupling, quarter-turn forcing
    write_reg(REG_INIT_FREQ, MOST_NEG);
    write_reg(REG_PHASE_GAIN, '0);
    write_reg(REG_FORCING_STEP, QUARTER);
    write_reg(REG_INIT_PHASE, QUARTER + 48'h1);
    bad_idx = CFG_IDX_W'(REG_INIT_PHASE) + 1'b1;
    write_reg(bad_idx, '0);   // unknown index, must not land anywhere
    @(negedge clk_i);
    step_words.push_back(1'b1);
    repeat (5) step_words.push_back(1'b0);
    settle();

    for (int b = 0; b < 8; b++) begin
      if (b == 7) calm = 1'b1;
      if ($urandom_range(0, 3) != 0) write_reg(REG_PHASE_GAIN, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(REG_FREQ_GAIN, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(REG_FORCING_STEP, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(REG_INIT_FREQ, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(REG_INIT_PHASE, pick_value());
      if ($urandom_range(0, 3) == 0) begin
        bad_idx = CFG_IDX_W'(REG_INIT_PHASE) + CFG_IDX_W'($urandom_range(1, 3));
        write_reg(bad_idx, pick_value());
      end
      @(negedge clk_i);
      if ($urandom_range(0, 1) == 0) step_words.push_back(1'b1);
      repeat (85) step_words.push_back($urandom_range(0, 11) == 0);
      settle();
    end

    if (errors == 0 && due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[adaptive_frequency_oscillator_step_top.f]
rtl/adfo_pkg.sv
rtl/adfo_if.sv
rtl/adaptive_frequency_oscillator_step_top.sv
test/adaptive_frequency_oscillator_step_top_tb.sv
